### rtl/rycs_pkg.sv
// Shared widths, constants, register codes and stage types of the rotary cos/sin generator.
package rycs_pkg;

	localparam int MAX_PAIRS = 64;
	localparam int PC_W      = 7;
	localparam int IDX_W     = 6;
	localparam int POS_W     = 24;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THETA_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_FACTOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ATTN_FACTOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_LOW    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_HIGH   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_INV     = 3'd7;

	localparam logic [PC_W-1:0]   PAIR_COUNT_RST  = 7'd64;
	localparam logic [DATA_W-1:0] THETA_SCALE_RST = 32'd3719290000;
	localparam logic [DATA_W-1:0] FREQ_SCALE_RST  = 32'd1073741824;
	localparam logic [DATA_W-1:0] ATTN_FACTOR_RST = 32'd1073741824;
	localparam logic [DATA_W-1:0] CORR_HIGH_RST   = 32'd4194304;
	localparam logic [DATA_W-1:0] POWER_ONE       = 32'hFFFF_FFFF;

	localparam int EXT_W    = 56;  // position * power
	localparam int INTERP_W = 58;  // interpolated angle and |extrap - interp|
	localparam int DELTA_W  = 60;
	localparam int TMAG_W   = 61;  // |theta|, Q.32
	localparam int REM_W    = 33;  // ramp divider remainder
	localparam int QUO_W    = 30;
	localparam int DIV_N    = 30;
	localparam int QT_W     = 27;  // quotient bits of |theta| / 2pi
	localparam int RED_W    = 36;  // holds a remainder below 4pi, Q.32
	localparam int ANG_W    = 34;
	localparam int CW       = 33;
	localparam int CORDIC_N = 30;
	localparam int AMP_W    = 38;

	localparam logic [34:0]              Q32_TWO_PI   = 35'd26986075409;
	localparam logic [31:0]              RECIP_TWO_PI = 32'((65'd1 << 64) / 65'(Q32_TWO_PI));
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI   = 34'sd6746518852;
	localparam logic signed [ANG_W-1:0] Q30_PI       = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI  = 34'sd1686629713;
	localparam logic signed [CW-1:0]    CORDIC_GAIN  = 33'sd652032874;
	localparam logic [DATA_W-1:0]       TENTH_Q32    = 32'd429496730;
	localparam logic [REM_W-1:0]        RAMP_MIN_Q16 = 33'd66;
	localparam logic [30:0]             ONE_Q30      = 31'h4000_0000;
	localparam logic signed [33:0]      ONE_Q24      = 34'sd16777216;

	typedef struct packed {
		logic                v;
		logic [IDX_W-1:0]    idx;
		logic                last;
		logic                sat;
		logic [INTERP_W-1:0] interp;
		logic                dneg;
		logic [INTERP_W-1:0] dmag;
		logic [REM_W-1:0]    rem;
		logic [QUO_W-1:0]    q;
	} div_t;

	typedef struct packed {
		logic              v;
		logic [IDX_W-1:0]  idx;
		logic              last;
		logic              tneg;
		logic [TMAG_W-1:0] rem;
	} mod_t;

	typedef struct packed {
		logic                    v;
		logic [IDX_W-1:0]        idx;
		logic                    last;
		logic                    flip;
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ANG_W-1:0] z;
	} cordic_t;

	function automatic logic [29:0] atan_q30(input int k);
		logic [29:0] r;
		case (k)
			0: r = 30'd843314857;
			1: r = 30'd497837829;
			2: r = 30'd263043837;
			3: r = 30'd133525159;
			4: r = 30'd67021687;
			5: r = 30'd33543516;
			6: r = 30'd16775851;
			7: r = 30'd8388437;
			8: r = 30'd4194283;
			9: r = 30'd2097149;
			default: r = 30'(30'd1 << (30 - k));
		endcase
		return r;
	endfunction

	// sign the magnitude and clamp to the signed 32-bit range
	function automatic logic [DATA_W-1:0] sat_out(input logic neg, input logic [38:0] m);
		logic [DATA_W-1:0] r;
		if (neg) begin
			r = (m > 39'h0_8000_0000) ? 32'h8000_0000 : 32'(-m);
		end else begin
			r = (m > 39'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/rycs_cordic.sv
// Rotation-mode CORDIC pipeline, one iteration per register stage.
module rycs_cordic import rycs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  cordic_t din,
	output cordic_t dout
);

	cordic_t st_s [0:CORDIC_N];

	assign st_s[0] = din;

	for (genvar k = 0; k < CORDIC_N; k++) begin : g_iter
		localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(k));
		cordic_t nxt;

		always_comb begin
			nxt = st_s[k];
			if (st_s[k].z >= 0) begin
				nxt.x = st_s[k].x - (st_s[k].y >>> k);
				nxt.y = st_s[k].y + (st_s[k].x >>> k);
				nxt.z = st_s[k].z - ATAN;
			end else begin
				nxt.x = st_s[k].x + (st_s[k].y >>> k);
				nxt.y = st_s[k].y - (st_s[k].x >>> k);
				nxt.z = st_s[k].z + ATAN;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_s[k+1].v <= 1'b0;
			end else if (en) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	assign dout = st_s[CORDIC_N];

endmodule

### rtl/rope_yarn_cos_sin_generator_core.sv
// Top level of the rotary cos/sin generator: config, row sequencer and angle pipeline.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_ready    | position
//  result   | out_valid / out_ready  | pair_index, cos_value, sin_value, last_pair
//  config   | cfg_write              | cfg_index, cfg_data
//
// One position yields min(pair_count, 64) results, one per cycle from the row sequencer while the
// pipeline is not stalled; a new position is accepted only once the sequencer has issued every
// pair of the previous one.
// Reset clears all valid bits and returns the registers to their defaults.
// A stalled result freezes the whole pipeline and the sequencer; nothing is dropped.
module rope_yarn_cos_sin_generator_core import rycs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [POS_W-1:0]     position,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     pair_index,
	output logic [DATA_W-1:0]    cos_value,
	output logic [DATA_W-1:0]    sin_value,
	output logic                 last_pair,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	// ---------------- configuration ----------------
	logic [PC_W-1:0]   pair_count_q;
	logic [DATA_W-1:0] theta_scale_q, freq_scale_q, ext_factor_q, attn_factor_q;
	logic [DATA_W-1:0] corr_low_q, corr_high_q, log_inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q  <= PAIR_COUNT_RST;
			theta_scale_q <= THETA_SCALE_RST;
			freq_scale_q  <= FREQ_SCALE_RST;
			ext_factor_q  <= '0;
			attn_factor_q <= ATTN_FACTOR_RST;
			corr_low_q    <= '0;
			corr_high_q   <= CORR_HIGH_RST;
			log_inv_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PAIR_COUNT:  pair_count_q  <= cfg_data[PC_W-1:0];
				REG_THETA_SCALE: theta_scale_q <= cfg_data;
				REG_FREQ_SCALE:  freq_scale_q  <= cfg_data;
				REG_EXT_FACTOR:  ext_factor_q  <= cfg_data;
				REG_ATTN_FACTOR: attn_factor_q <= cfg_data;
				REG_CORR_LOW:    corr_low_q    <= cfg_data;
				REG_CORR_HIGH:   corr_high_q   <= cfg_data;
				REG_LOG_INV:     log_inv_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ramp denominator and magnitude, derived from config only
	logic [REM_W-1:0]  den_q;
	logic [DATA_W-1:0] tenth_q;
	logic              lg_neg_q;
	logic [29:0]       f_mag_q;
	logic              f_neg_q;
	logic [AMP_W-1:0]  amp_mag_q;
	logic              amp_neg_q;

	logic signed [33:0] den_diff;
	logic [DATA_W-1:0]  lg_mag;
	logic [63:0]        tenth_prod;
	logic signed [33:0] f_val;
	logic [61:0]        amp_prod;

	always_comb begin
		den_diff   = $signed({{2{corr_high_q[31]}}, corr_high_q})
			- $signed({{2{corr_low_q[31]}}, corr_low_q});
		lg_mag     = log_inv_q[31] ? 32'(-log_inv_q) : log_inv_q;
		tenth_prod = 64'(lg_mag) * 64'(TENTH_Q32);
		f_val      = lg_neg_q ? (ONE_Q24 - $signed({2'b00, tenth_q}))
			: (ONE_Q24 + $signed({2'b00, tenth_q}));
		amp_prod   = 62'(attn_factor_q) * 62'(f_mag_q);
	end

	always_ff @(posedge clk) begin
		den_q     <= (den_diff < $signed({1'b0, RAMP_MIN_Q16})) ? RAMP_MIN_Q16
			: den_diff[REM_W-1:0];
		tenth_q   <= tenth_prod[63:32];
		lg_neg_q  <= log_inv_q[31];
		f_neg_q   <= f_val[33];
		f_mag_q   <= f_val[33] ? 30'(-f_val) : f_val[29:0];
		amp_mag_q <= (ext_factor_q != '0) ? amp_prod[61:24] : AMP_W'(attn_factor_q);
		amp_neg_q <= (ext_factor_q != '0) && f_neg_q;
	end

	// ---------------- row sequencer ----------------
	logic              adv;
	logic              busy_q;
	logic [PC_W-1:0]   cnt_q, count_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] tp_q;
	logic [PC_W-1:0]   eff_count;
	logic [63:0]       tp_prod;
	logic              seq_last;

	assign in_ready  = !busy_q;
	assign eff_count = (pair_count_q > PC_W'(MAX_PAIRS)) ? PC_W'(MAX_PAIRS) : pair_count_q;
	assign tp_prod   = 64'(tp_q) * 64'(theta_scale_q);
	assign seq_last  = (cnt_q + 1'b1) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			count_q <= '0;
		end else if (in_valid && in_ready) begin
			busy_q  <= eff_count != '0;
			cnt_q   <= '0;
			count_q <= eff_count;
		end else if (busy_q && adv) begin
			cnt_q <= cnt_q + 1'b1;
			if (seq_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pos_q <= position;
			tp_q  <= POWER_ONE;
		end else if (busy_q && adv) begin
			tp_q <= tp_prod[63:32];
		end
	end

	// ---------------- angle pipeline ----------------
	// stage 1: extrapolated angle, ramp numerator
	logic                  v_s1, last_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [EXT_W-1:0]      extrap_s1;
	logic signed [34:0]    num_s1;
	// stage 2: interpolation partial products, divider start
	logic                  v_s2, last_s2, sat_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [EXT_W-1:0]      extrap_s2;
	logic [63:0]           pp_lo_s2;
	logic [55:0]           pp_hi_s2;
	logic [REM_W-1:0]      rem_s2;
	// stage 3: interpolated angle
	logic                  v_s3, last_s3, sat_s3;
	logic [IDX_W-1:0]      idx_s3;
	logic [EXT_W-1:0]      extrap_s3;
	logic [INTERP_W-1:0]   interp_s3;
	logic [REM_W-1:0]      rem_s3;

	logic signed [34:0]    den_s;
	logic signed [58:0]    d_val;

	assign den_s = $signed({2'b00, den_q});
	assign d_val = $signed({3'b000, extrap_s3}) - $signed({1'b0, interp_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1    <= cnt_q[IDX_W-1:0];
			last_s1   <= seq_last;
			extrap_s1 <= EXT_W'(pos_q) * EXT_W'(tp_q);
			num_s1    <= $signed({12'b0, cnt_q, 16'b0})
				- $signed({{3{corr_low_q[31]}}, corr_low_q});

			idx_s2    <= idx_s1;
			last_s2   <= last_s1;
			extrap_s2 <= extrap_s1;
			pp_lo_s2  <= 64'(extrap_s1[31:0]) * 64'(freq_scale_q);
			pp_hi_s2  <= 56'(extrap_s1[55:32]) * 56'(freq_scale_q);
			sat_s2    <= num_s1 >= den_s;
			rem_s2    <= (num_s1 > 0 && num_s1 < den_s) ? num_s1[REM_W-1:0] : '0;

			idx_s3    <= idx_s2;
			last_s3   <= last_s2;
			sat_s3    <= sat_s2;
			extrap_s3 <= extrap_s2;
			rem_s3    <= rem_s2;
			interp_s3 <= {pp_hi_s2, 2'b00} + INTERP_W'(pp_lo_s2[63:30]);
		end
	end

	// ramp divider: one quotient bit per stage
	div_t div_s [0:DIV_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0].v <= 1'b0;
		end else if (adv) begin
			div_s[0].v      <= v_s3;
			div_s[0].idx    <= idx_s3;
			div_s[0].last   <= last_s3;
			div_s[0].sat    <= sat_s3;
			div_s[0].interp <= interp_s3;
			div_s[0].dneg   <= d_val[58];
			div_s[0].dmag   <= d_val[58] ? INTERP_W'(-d_val) : d_val[INTERP_W-1:0];
			div_s[0].rem    <= rem_s3;
			div_s[0].q      <= '0;
		end
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [REM_W:0] sh;
		div_t           nxt;

		always_comb begin
			sh  = {div_s[k].rem, 1'b0};
			nxt = div_s[k];
			if (sh >= {1'b0, den_q}) begin
				nxt.rem = REM_W'(sh - {1'b0, den_q});
				nxt.q   = {div_s[k].q[QUO_W-2:0], 1'b1};
			end else begin
				nxt.rem = sh[REM_W-1:0];
				nxt.q   = {div_s[k].q[QUO_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k+1].v <= 1'b0;
			end else if (adv) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	// mix factor, correction and full angle
	logic                 v_m_s, last_m_s, dneg_m_s;
	logic [IDX_W-1:0]     idx_m_s;
	logic [INTERP_W-1:0]  interp_m_s, dmag_m_s;
	logic [DATA_W-1:0]    mix_m_s;
	logic                 v_p_s, last_p_s, dneg_p_s;
	logic [IDX_W-1:0]     idx_p_s;
	logic [INTERP_W-1:0]  interp_p_s;
	logic [63:0]          pd_lo_p_s;
	logic [57:0]          pd_hi_p_s;
	logic                 v_dl_s, last_dl_s, dneg_dl_s;
	logic [IDX_W-1:0]     idx_dl_s;
	logic [INTERP_W-1:0]  interp_dl_s;
	logic [DELTA_W-1:0]   delta_dl_s;

	logic [30:0]          ramp_t, ramp_r;
	logic [62:0]          mix_prod;
	logic signed [61:0]   theta_val;

	always_comb begin
		ramp_t    = div_s[DIV_N].sat ? ONE_Q30 : {1'b0, div_s[DIV_N].q};
		ramp_r    = ONE_Q30 - ramp_t;
		mix_prod  = 63'(ext_factor_q) * 63'(ramp_r);
		theta_val = dneg_dl_s ? ($signed({4'b0, interp_dl_s}) - $signed({2'b0, delta_dl_s}))
			: ($signed({4'b0, interp_dl_s}) + $signed({2'b0, delta_dl_s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_s  <= 1'b0;
			v_p_s  <= 1'b0;
			v_dl_s <= 1'b0;
		end else if (adv) begin
			v_m_s  <= div_s[DIV_N].v;
			v_p_s  <= v_m_s;
			v_dl_s <= v_p_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_m_s     <= div_s[DIV_N].idx;
			last_m_s    <= div_s[DIV_N].last;
			dneg_m_s    <= div_s[DIV_N].dneg;
			interp_m_s  <= div_s[DIV_N].interp;
			dmag_m_s    <= div_s[DIV_N].dmag;
			mix_m_s     <= mix_prod[61:30];

			idx_p_s     <= idx_m_s;
			last_p_s    <= last_m_s;
			dneg_p_s    <= dneg_m_s;
			interp_p_s  <= interp_m_s;
			pd_lo_p_s   <= 64'(dmag_m_s[31:0]) * 64'(mix_m_s);
			pd_hi_p_s   <= 58'(dmag_m_s[57:32]) * 58'(mix_m_s);

			idx_dl_s    <= idx_p_s;
			last_dl_s   <= last_p_s;
			dneg_dl_s   <= dneg_p_s;
			interp_dl_s <= interp_p_s;
			delta_dl_s  <= {pd_hi_p_s, 2'b00} + DELTA_W'(pd_lo_p_s[63:30]);
		end
	end

	// reduce |theta| modulo 2pi: reciprocal estimate of the quotient (never above the true
	// one, at most one below), multiply back, subtract, then one correcting subtraction
	mod_t                 red_s;
	logic                 v_q_s, last_q_s, tneg_q_s;
	logic [IDX_W-1:0]     idx_q_s;
	logic [RED_W-1:0]     xlo_q_s;
	logic [QT_W-1:0]      quo_q_s;
	logic                 v_pq_s, last_pq_s, tneg_pq_s;
	logic [IDX_W-1:0]     idx_pq_s;
	logic [RED_W-1:0]     xlo_pq_s, qq_pq_s;
	logic                 v_r_s, last_r_s, tneg_r_s;
	logic [IDX_W-1:0]     idx_r_s;
	logic [RED_W-1:0]     rem_r_s;
	logic                 v_c_s, last_c_s, tneg_c_s;
	logic [IDX_W-1:0]     idx_c_s;
	logic [34:0]          rem_c_s;
	logic [58:0]          quo_prod;

	assign quo_prod = 59'(red_s.rem[TMAG_W-1:32]) * 59'(RECIP_TWO_PI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_s.v <= 1'b0;
		end else if (adv) begin
			red_s.v    <= v_dl_s;
			red_s.idx  <= idx_dl_s;
			red_s.last <= last_dl_s;
			red_s.tneg <= theta_val[61];
			red_s.rem  <= theta_val[61] ? TMAG_W'(-theta_val) : theta_val[TMAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q_s  <= 1'b0;
			v_pq_s <= 1'b0;
			v_r_s  <= 1'b0;
			v_c_s  <= 1'b0;
		end else if (adv) begin
			v_q_s  <= red_s.v;
			v_pq_s <= v_q_s;
			v_r_s  <= v_pq_s;
			v_c_s  <= v_r_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_q_s   <= red_s.idx;
			last_q_s  <= red_s.last;
			tneg_q_s  <= red_s.tneg;
			xlo_q_s   <= red_s.rem[RED_W-1:0];
			quo_q_s   <= quo_prod[QT_W+31:32];

			idx_pq_s  <= idx_q_s;
			last_pq_s <= last_q_s;
			tneg_pq_s <= tneg_q_s;
			xlo_pq_s  <= xlo_q_s;
			qq_pq_s   <= RED_W'(quo_q_s) * RED_W'(Q32_TWO_PI);

			idx_r_s   <= idx_pq_s;
			last_r_s  <= last_pq_s;
			tneg_r_s  <= tneg_pq_s;
			rem_r_s   <= xlo_pq_s - qq_pq_s;

			idx_c_s   <= idx_r_s;
			last_c_s  <= last_r_s;
			tneg_c_s  <= tneg_r_s;
			rem_c_s   <= (rem_r_s >= RED_W'(Q32_TWO_PI)) ? 35'(rem_r_s - RED_W'(Q32_TWO_PI))
				: rem_r_s[34:0];
		end
	end

	// floor fix, shift to Q.30, fold into [-pi/2, pi/2]
	logic                    v_f1_s, last_f1_s, v_f2_s, last_f2_s;
	logic [IDX_W-1:0]        idx_f1_s, idx_f2_s;
	logic signed [ANG_W-1:0] a_f1_s, a_f2_s;
	logic [34:0]             rem_fix;
	cordic_t                 fold, cin, cout;

	always_comb begin
		rem_fix = (tneg_c_s && rem_c_s != '0) ? (Q32_TWO_PI - rem_c_s) : rem_c_s;
		fold      = '0;
		fold.v    = v_f2_s;
		fold.idx  = idx_f2_s;
		fold.last = last_f2_s;
		fold.x    = CORDIC_GAIN;
		fold.y    = '0;
		fold.z    = a_f2_s;
		fold.flip = 1'b0;
		if (a_f2_s > Q30_HALF_PI) begin
			fold.z    = a_f2_s - Q30_PI;
			fold.flip = 1'b1;
		end else if (a_f2_s < -Q30_HALF_PI) begin
			fold.z    = a_f2_s + Q30_PI;
			fold.flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1_s <= 1'b0;
			v_f2_s <= 1'b0;
			cin.v  <= 1'b0;
		end else if (adv) begin
			v_f1_s <= v_c_s;
			v_f2_s <= v_f1_s;
			cin    <= fold;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_f1_s  <= idx_c_s;
			last_f1_s <= last_c_s;
			a_f1_s    <= $signed({1'b0, rem_fix[34:2]});
			idx_f2_s  <= idx_f1_s;
			last_f2_s <= last_f1_s;
			a_f2_s    <= (a_f1_s >= Q30_PI) ? (a_f1_s - Q30_TWO_PI) : a_f1_s;
		end
	end

	rycs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (cin),
		.dout   (cout)
	);

	// scale by magnitude and saturate
	logic                  v_o1_s, last_o1_s, cneg_o1_s, sneg_o1_s;
	logic [IDX_W-1:0]      idx_o1_s;
	logic [63:0]           cl_o1_s, sl_o1_s;
	logic [37:0]           ch_o1_s, sh_o1_s;
	logic                  v_o2_s;
	logic signed [CW-1:0]  cos_t, sin_t;
	logic [31:0]           cos_mag, sin_mag;

	always_comb begin
		cos_t   = cout.flip ? -cout.x : cout.x;
		sin_t   = cout.flip ? -cout.y : cout.y;
		cos_mag = cos_t[CW-1] ? 32'(-cos_t) : cos_t[31:0];
		sin_mag = sin_t[CW-1] ? 32'(-sin_t) : sin_t[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o1_s <= 1'b0;
			v_o2_s <= 1'b0;
		end else if (adv) begin
			v_o1_s <= cout.v;
			v_o2_s <= v_o1_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_o1_s   <= cout.idx;
			last_o1_s  <= cout.last;
			cneg_o1_s  <= cos_t[CW-1] ^ amp_neg_q;
			sneg_o1_s  <= sin_t[CW-1] ^ amp_neg_q;
			cl_o1_s    <= 64'(amp_mag_q[31:0]) * 64'(cos_mag);
			ch_o1_s    <= 38'(amp_mag_q[37:32]) * 38'(cos_mag);
			sl_o1_s    <= 64'(amp_mag_q[31:0]) * 64'(sin_mag);
			sh_o1_s    <= 38'(amp_mag_q[37:32]) * 38'(sin_mag);

			pair_index <= idx_o1_s;
			last_pair  <= last_o1_s;
			cos_value  <= sat_out(cneg_o1_s, 39'(ch_o1_s) + 39'(cl_o1_s[63:32]));
			sin_value  <= sat_out(sneg_o1_s, 39'(sh_o1_s) + 39'(sl_o1_s[63:32]));
		end
	end

	assign out_valid = v_o2_s;
	assign adv       = !v_o2_s || out_ready;

endmodule

### rtl/rycs_checker.sv
// Port-level checks on the input and result streams of the rotary cos/sin generator.
module rycs_checker import rycs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [POS_W-1:0]     position,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [IDX_W-1:0]     pair_index,
	input logic [DATA_W-1:0]    cos_value,
	input logic [DATA_W-1:0]    sin_value,
	input logic                 last_pair,
	input logic                 cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [DATA_W-1:0]    cfg_data
);

	logic [PC_W-1:0] exp_idx_q, pc_q, eff;

	assign eff = (pc_q > PC_W'(MAX_PAIRS)) ? PC_W'(MAX_PAIRS) : pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			pc_q      <= PAIR_COUNT_RST;
		end else begin
			if (out_valid && out_ready) begin
				exp_idx_q <= last_pair ? '0 : exp_idx_q + 1'b1;
			end
			if (cfg_write && cfg_index == REG_PAIR_COUNT) begin
				pc_q <= cfg_data[PC_W-1:0];
			end
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(position))
		else $error("input item changed while waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_index)
			&& $stable(cos_value) && $stable(sin_value) && $stable(last_pair))
		else $error("result changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pair_index == exp_idx_q[IDX_W-1:0])
		else $error("pair index out of sequence");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_pair == ((exp_idx_q + 1'b1) == eff))
		else $error("last pair flag misplaced");

endmodule

bind rope_yarn_cos_sin_generator_core rycs_checker u_rycs_checker (.*);

### tb/rope_yarn_cos_sin_generator_core_tb.sv
// Testbench for the rotary cos/sin generator: bit-exact predictor, random handshakes, checker.
module rope_yarn_cos_sin_generator_core_tb;
	import rycs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TWO_PI_Q32  = 64'sd26986075409;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_START  = 64'sd652032874;
	localparam longint UNIT_Q30    = 64'sd1073741824;
	localparam longint UNIT_Q24    = 64'sd16777216;
	localparam longint MIN_SPAN    = 64'sd66;
	localparam logic [31:0] TENTH  = 32'd429496730;
	localparam longint ARCTAN [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] cos_v;
		logic [DATA_W-1:0] sin_v;
		logic              last;
	} pair_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [POS_W-1:0]     position = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IDX_W-1:0]     pair_index;
	logic [DATA_W-1:0]    cos_value;
	logic [DATA_W-1:0]    sin_value;
	logic                 last_pair;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	// predictor copy of the registers
	logic [PC_W-1:0] m_pairs;
	logic [31:0] m_ratio, m_freq, m_ext, m_attn, m_low, m_high, m_log;

	pair_t pair_q[$];
	int    send_idle = 0;
	int    recv_idle = 0;
	int    hold_cycles = 0;
	int    err_count = 0;
	int    items_sent = 0;
	int    results_seen = 0;

	rope_yarn_cos_sin_generator_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mul_floor(input logic [63:0] a, input logic [31:0] b,
			input int sh);
		logic [127:0] p;
		p = {64'd0, a} * {96'd0, b};
		return 64'(p >> sh);
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] scale_trig(input longint trig, input longint amp);
		logic [63:0] m;
		bit neg;
		logic [31:0] r;
		m = mul_floor(64'(abs64(amp)), 32'(abs64(trig)), 32);
		neg = (trig < 0) != (amp < 0);
		if (neg)
			r = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
		else
			r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		return r;
	endfunction

	task automatic rotate_angle(input longint th, output longint c, output longint s);
		longint r, a, x, y, nx;
		bit flip;
		r = th % TWO_PI_Q32;
		if (r < 0) r += TWO_PI_Q32;
		a = r >>> 2;
		x = GAIN_START;
		y = 0;
		flip = 1'b0;
		if (a >= PI_Q30) a -= TWO_PI_Q30;
		// fold into the right half-plane, undo by negating at the end
		if (a > HALF_PI_Q30) begin
			a -= PI_Q30;
			flip = 1'b1;
		end else if (a < -HALF_PI_Q30) begin
			a += PI_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < 30; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				a -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				a += ARCTAN[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// queue the cos/sin pairs one position produces
	task automatic predict_pairs(input logic [POS_W-1:0] pos);
		int count;
		longint amp, low, span, lg, tenth, f, a, extrap, interp, theta, d, num, c, s;
		logic [63:0] t, r, mix;
		logic [31:0] power;
		pair_t e;
		count = (m_pairs > MAX_PAIRS) ? MAX_PAIRS : int'(m_pairs);
		amp = longint'(m_attn);
		low = longint'(signed'(m_low));
		span = longint'(signed'(m_high)) - low;
		if (span < MIN_SPAN) span = MIN_SPAN;
		power = 32'hFFFF_FFFF;
		if (m_ext != 0) begin
			lg = longint'(signed'(m_log));
			tenth = longint'(mul_floor(64'(abs64(lg)), TENTH, 32));
			f = UNIT_Q24 + (lg < 0 ? -tenth : tenth);
			a = longint'(mul_floor(64'(m_attn), 32'(abs64(f)), 24));
			amp = f < 0 ? -a : a;
		end
		for (int i = 0; i < count; i++) begin
			extrap = longint'({40'd0, pos}) * longint'({32'd0, power});
			interp = longint'(mul_floor(64'(extrap), m_freq, 30));
			theta = interp;
			if (m_ext != 0) begin
				num = longint'(i) * 65536 - low;
				d = extrap - interp;
				if (num <= 0) t = 0;
				else if (num >= span) t = 64'(UNIT_Q30);
				else t = 64'(num <<< 30) / 64'(span);
				r = 64'(UNIT_Q30) - t;
				mix = mul_floor(64'(m_ext), r[31:0], 30);
				if (d >= 0) theta += longint'(mul_floor(64'(d), mix[31:0], 30));
				else theta -= longint'(mul_floor(64'(-d), mix[31:0], 30));
			end
			rotate_angle(theta, c, s);
			e.idx = IDX_W'(i);
			e.cos_v = scale_trig(c, amp);
			e.sin_v = scale_trig(s, amp);
			e.last = (i + 1 == count);
			pair_q.push_back(e);
			power = 32'(mul_floor(64'(power), m_ratio, 32));
		end
	endtask

	task automatic send_position(input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		position = pos;
		do @(posedge clk); while (!in_ready);
		predict_pairs(pos);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// wait out every queued pair, then let the pipeline empty of rows with no results
	task automatic drain;
		while (pair_q.size() != 0) @(negedge clk);
		repeat (130) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_PAIR_COUNT:  m_pairs = val[PC_W-1:0];
			REG_THETA_SCALE: m_ratio = val;
			REG_FREQ_SCALE:  m_freq = val;
			REG_EXT_FACTOR:  m_ext = val;
			REG_ATTN_FACTOR: m_attn = val;
			REG_CORR_LOW:    m_low = val;
			REG_CORR_HIGH:   m_high = val;
			REG_LOG_INV:     m_log = val;
			default: ;
		endcase
	endtask

	task automatic random_config(input int max_pairs);
		drain();
		write_reg(REG_PAIR_COUNT, 32'($urandom_range(max_pairs, 1)));
		write_reg(REG_THETA_SCALE, $urandom());
		write_reg(REG_FREQ_SCALE, $urandom());
		write_reg(REG_EXT_FACTOR, ($urandom_range(3) == 0) ? 32'd0 : $urandom());
		write_reg(REG_ATTN_FACTOR, $urandom());
		write_reg(REG_CORR_LOW, 32'($urandom_range(20 << 16)) - 32'(4 << 16));
		write_reg(REG_CORR_HIGH, ($urandom_range(7) == 0) ? $urandom()
			: 32'($urandom_range(70 << 16)));
		write_reg(REG_LOG_INV, $urandom());
	endtask

	function automatic logic [POS_W-1:0] rand_position();
		return ($urandom_range(1) == 0) ? POS_W'($urandom()) : POS_W'($urandom_range(4095));
	endfunction

	task automatic test_defaults;
		send_position('0);
		send_position(24'd1);
		send_position(24'hFF_FFFF);
		send_position(24'd4096);
	endtask

	task automatic test_ramp_and_magnitude;
		drain();
		write_reg(REG_EXT_FACTOR, 32'h4000_0000);
		write_reg(REG_CORR_LOW, 32'(8 << 16));
		write_reg(REG_CORR_HIGH, 32'(40 << 16));
		write_reg(REG_LOG_INV, 32'h0800_0000);
		write_reg(REG_FREQ_SCALE, 32'h1000_0000);
		send_position(24'd777);
		send_position(24'hFF_FFFF);
		// large magnitude factor saturates the outputs
		drain();
		write_reg(REG_ATTN_FACTOR, 32'hFFFF_FFFF);
		write_reg(REG_LOG_INV, 32'h7FFF_FFFF);
		send_position(24'd123456);
		// negative magnitude factor, inverted ramp bounds clamp to the minimum span
		drain();
		write_reg(REG_LOG_INV, 32'h8000_0000);
		write_reg(REG_CORR_LOW, 32'h7FFF_FFFF);
		write_reg(REG_CORR_HIGH, 32'h8000_0000);
		write_reg(REG_EXT_FACTOR, 32'hFFFF_FFFF);
		send_position(24'h80_0000);
		drain();
		write_reg(REG_THETA_SCALE, '0);
		write_reg(REG_FREQ_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_ATTN_FACTOR, '0);
		send_position(24'h55_5555);
	endtask

	task automatic test_pair_counts;
		drain();
		write_reg(REG_ATTN_FACTOR, 32'h4000_0000);
		write_reg(REG_PAIR_COUNT, '0);
		send_position(24'd99);
		send_position(24'd100);
		drain();
		write_reg(REG_PAIR_COUNT, 32'd1);
		send_position(24'hAA_AAAA);
		send_position(24'd5);
		drain();
		// above the maximum saturates; bit 7 is dropped by the register width
		write_reg(REG_PAIR_COUNT, 32'd127);
		send_position(24'd31);
		drain();
		write_reg(REG_PAIR_COUNT, 32'd128);
		send_position(24'd32);
		drain();
		write_reg(REG_PAIR_COUNT, 32'd65);
		send_position(24'd33);
	endtask

	task automatic test_random(input int s_idle, input int r_idle, input int n);
		random_config(16);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2) random_config(($urandom_range(3) == 0) ? 64 : 12);
			send_position(rand_position());
		end
	endtask

	task automatic test_back_pressure;
		random_config(64);
		write_reg(REG_PAIR_COUNT, 32'd40);
		send_idle = 0;
		recv_idle = 10;
		hold_cycles = 600;
		for (int k = 0; k < 12; k++) send_position(rand_position());
		// pause the sender until every pair has arrived
		while (pair_q.size() != 0) @(negedge clk);
		for (int k = 0; k < 6; k++) send_position(rand_position());
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready = 1'b0;
			hold_cycles--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		pair_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pair_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected pair %0d cos %h sin %h", pair_index, cos_value,
						sin_value);
			end else begin
				e = pair_q.pop_front();
				if (pair_index !== e.idx || cos_value !== e.cos_v || sin_value !== e.sin_v
						|| last_pair !== e.last) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: exp idx %0d cos %h sin %h last %b, got idx %0d cos %h sin %h last %b",
							e.idx, e.cos_v, e.sin_v, e.last, pair_index, cos_value,
							sin_value, last_pair);
				end
			end
		end
	end

	initial begin
		m_pairs = PAIR_COUNT_RST;
		m_ratio = THETA_SCALE_RST;
		m_freq = FREQ_SCALE_RST;
		m_ext = '0;
		m_attn = ATTN_FACTOR_RST;
		m_low = '0;
		m_high = CORR_HIGH_RST;
		m_log = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		recv_idle = 30;
		test_defaults();
		test_ramp_and_magnitude();
		test_pair_counts();
		test_random(22, 59, 45);
		test_random(59, 22, 45);
		test_random(0, 0, 45);
		test_back_pressure();
		drain();
		repeat (20) @(negedge clk);
		if (pair_q.size() != 0) err_count++;
		$display("covered %0d positions and %0d pairs over ramp, magnitude and pair count settings",
			items_sent, results_seen);
		$display("with idling on both sides, a long receiver hold and a full drain pause");
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
rtl/rycs_pkg.sv
rtl/rycs_cordic.sv
rtl/rope_yarn_cos_sin_generator_core.sv
rtl/rycs_checker.sv
tb/rope_yarn_cos_sin_generator_core_tb.sv
